// File: hdl/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

   // request actions
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_STATUS = 2'd2;

   // transfer modes
   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_SUB_RD = 2'd1;
   localparam logic [1:0] MODE_SUB_WR = 2'd2;
   localparam logic [1:0] MODE_RSVD   = 2'd3;

   // controller status codes
   localparam logic [7:0] ST_START       = 8'h08;
   localparam logic [7:0] ST_RESTART     = 8'h10;
   localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
   localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST    = 8'h38;
   localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
   localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
   localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

   localparam logic [7:0] ADDR_WR_MASK = 8'hFE;

   // control register bits
   localparam logic [6:0] CTL_ACK       = 7'h04;
   localparam logic [6:0] CTL_SI        = 7'h08;
   localparam logic [6:0] CTL_STOP      = 7'h10;
   localparam logic [6:0] CTL_START     = 7'h20;
   localparam logic [6:0] CTL_EN        = 7'h40;
   localparam logic [6:0] CLR_SI_STA    = 7'h28;
   localparam logic [6:0] CLR_AA_SI_STA = 7'h2C;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_ADDR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 2'd3;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic [6:0] control_set;
      logic [6:0] control_clear;
      logic       store_valid;
      logic [7:0] store_byte;
      logic [7:0] store_index;
      logic       finished;
      logic       failed;
   } rsp_type;

   typedef struct packed {
      rsp_type rsp;
      logic    from_mem;
   } stage_type;

endpackage

// File: hdl/i2cms_req_if.sv
`timescale 1ns / 1ps

interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] status_code;
   logic [7:0] received_byte;
   logic [7:0] load_byte;
   logic [7:0] load_index;

   modport source (output valid, output action, output status_code,
                   output received_byte, output load_byte, output load_index,
                   input ready);
   modport sink   (input valid, input action, input status_code,
                   input received_byte, input load_byte, input load_index,
                   output ready);
endinterface

// File: hdl/i2cms_rsp_if.sv
`timescale 1ns / 1ps

interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic       send_valid;
   logic [7:0] send_byte;
   logic [6:0] control_set;
   logic [6:0] control_clear;
   logic       store_valid;
   logic [7:0] store_byte;
   logic [7:0] store_index;
   logic       finished;
   logic       failed;

   modport source (output valid, output send_valid, output send_byte,
                   output control_set, output control_clear, output store_valid,
                   output store_byte, output store_index, output finished,
                   output failed, input ready);
   modport sink   (input valid, input send_valid, input send_byte,
                   input control_set, input control_clear, input store_valid,
                   input store_byte, input store_index, input finished,
                   input failed, output ready);
endinterface

// File: hdl/i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps

// I2C master transfer sequencer. Each request beat (transmit byte load, start
// command or controller status event) yields exactly one response beat telling
// the controller what to write to its data register and which control bits to
// set and clear, plus any received byte and a finished or failed mark. A new
// request is taken every cycle unless the response side stalls; a beat passes
// a stage register, with the registered read of the transmit buffer memory,
// then the response register. State is updated in the accept cycle, so
// back-to-back beats see each other's effects. The transmit buffer holds
// BUFFER_DEPTH bytes and is not cleared by reset; an unloaded entry sends an
// unspecified byte. The user must write registers through csr_we, csr_index
// and csr_wdata only while no transfer beat is in flight (unenforced).
module i2c_master_transfer_sequencer #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   i2cms_req_if.sink                         req_chan,
   i2cms_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  logic [i2cms_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   function automatic logic [AW-1:0] slot_of(input logic [7:0] x);
      logic [AW-1:0] r;
      r = '0;
      for (int i = 0; i < 256; i++) begin
         if (x == 8'(i)) r = AW'(i % BUFFER_DEPTH);
      end
      return r;
   endfunction

   // configuration
   logic [7:0] slave_addr_ff, sub_addr_ff, count_ff;
   logic [1:0] mode_ff;

   // transfer state
   logic [1:0] phase_ff, phase_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] position_ff, position_in;

   logic [7:0] mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;
   logic       mem_we;

   logic                  s1_valid_ff;
   i2cms_pkg::stage_type  s1_ff, s1_in;
   logic                  rsp_valid_ff;
   i2cms_pkg::rsp_type    rsp_ff, rsp_in;

   logic       fire, s1_move;
   logic [1:0] start_mode;
   logic [7:0] next_pos, rx_left;

   assign s1_move        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign fire           = req_chan.valid && req_chan.ready;

   assign next_pos   = (position_ff == 8'(BUFFER_DEPTH - 1)) ? 8'd0 : position_ff + 8'd1;
   assign start_mode = (mode_ff == i2cms_pkg::MODE_RSVD) ? i2cms_pkg::MODE_PLAIN : mode_ff;
   assign rx_left    = (req_chan.status_code == i2cms_pkg::ST_DATA_R_ACK) ?
                       bytes_left_ff - 8'd1 : bytes_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= '0;
         sub_addr_ff   <= '0;
         count_ff      <= 8'd1;
         mode_ff       <= i2cms_pkg::MODE_PLAIN;
      end else if (csr_we) begin
         case (csr_index)
            i2cms_pkg::CSR_SLAVE_ADDR: slave_addr_ff <= csr_wdata;
            i2cms_pkg::CSR_SUB_ADDR:   sub_addr_ff   <= csr_wdata;
            i2cms_pkg::CSR_COUNT:      count_ff      <= csr_wdata;
            i2cms_pkg::CSR_MODE:       mode_ff       <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      position_in   = position_ff;
      mem_we        = 1'b0;
      s1_in         = '0;
      case (req_chan.action)
         i2cms_pkg::ACT_LOAD: begin
            mem_we = 1'b1;
         end
         i2cms_pkg::ACT_START: begin
            if (start_mode == i2cms_pkg::MODE_SUB_RD && count_ff == 8'd0) begin
               s1_in.rsp.failed = 1'b1;
            end else begin
               phase_in                = start_mode;
               bytes_left_in           = count_ff;
               position_in             = '0;
               s1_in.rsp.control_clear = i2cms_pkg::CLR_AA_SI_STA;
               s1_in.rsp.control_set   = i2cms_pkg::CTL_START | i2cms_pkg::CTL_EN;
            end
         end
         i2cms_pkg::ACT_STATUS: begin
            case (req_chan.status_code) inside
               i2cms_pkg::ST_START: begin
                  s1_in.rsp.send_valid    = 1'b1;
                  s1_in.rsp.send_byte     = (phase_ff == i2cms_pkg::MODE_SUB_RD) ?
                                            (slave_addr_ff & i2cms_pkg::ADDR_WR_MASK) :
                                            slave_addr_ff;
                  s1_in.rsp.control_clear = i2cms_pkg::CLR_SI_STA;
               end
               i2cms_pkg::ST_RESTART: begin
                  s1_in.rsp.send_valid    = 1'b1;
                  s1_in.rsp.send_byte     = slave_addr_ff;
                  s1_in.rsp.control_clear = i2cms_pkg::CLR_SI_STA;
               end
               i2cms_pkg::ST_ADDR_W_ACK, i2cms_pkg::ST_DATA_W_ACK: begin
                  if (phase_ff == i2cms_pkg::MODE_PLAIN) begin
                     s1_in.rsp.control_clear = i2cms_pkg::CLR_SI_STA;
                     if (bytes_left_ff != 8'd0) begin
                        s1_in.rsp.send_valid = 1'b1;
                        s1_in.from_mem       = 1'b1;
                        position_in          = next_pos;
                        bytes_left_in        = bytes_left_ff - 8'd1;
                     end else begin
                        s1_in.rsp.control_set = i2cms_pkg::CTL_STOP;
                        s1_in.rsp.finished    = 1'b1;
                     end
                  end else if (req_chan.status_code == i2cms_pkg::ST_ADDR_W_ACK) begin
                     s1_in.rsp.send_valid    = 1'b1;
                     s1_in.rsp.send_byte     = sub_addr_ff;
                     s1_in.rsp.control_clear = i2cms_pkg::CLR_SI_STA;
                     if (phase_ff == i2cms_pkg::MODE_SUB_WR) phase_in = i2cms_pkg::MODE_PLAIN;
                  end else if (phase_ff == i2cms_pkg::MODE_SUB_RD) begin
                     s1_in.rsp.control_set   = i2cms_pkg::CTL_START;
                     s1_in.rsp.control_clear = i2cms_pkg::CTL_SI;
                     phase_in                = i2cms_pkg::MODE_PLAIN;
                  end
               end
               i2cms_pkg::ST_ADDR_W_NACK, i2cms_pkg::ST_DATA_W_NACK,
               i2cms_pkg::ST_ARB_LOST, i2cms_pkg::ST_ADDR_R_NACK: begin
                  s1_in.rsp.control_clear = i2cms_pkg::CLR_SI_STA;
                  s1_in.rsp.failed        = 1'b1;
               end
               i2cms_pkg::ST_ADDR_R_ACK, i2cms_pkg::ST_DATA_R_ACK: begin
                  if (req_chan.status_code == i2cms_pkg::ST_DATA_R_ACK) begin
                     s1_in.rsp.store_valid = 1'b1;
                     s1_in.rsp.store_byte  = req_chan.received_byte;
                     s1_in.rsp.store_index = position_ff;
                     position_in           = next_pos;
                  end
                  bytes_left_in = rx_left;
                  if (rx_left == 8'd1) begin
                     s1_in.rsp.control_clear = i2cms_pkg::CLR_AA_SI_STA;
                  end else begin
                     s1_in.rsp.control_set   = i2cms_pkg::CTL_ACK;
                     s1_in.rsp.control_clear = i2cms_pkg::CLR_SI_STA;
                  end
               end
               i2cms_pkg::ST_DATA_R_NACK: begin
                  s1_in.rsp.store_valid   = 1'b1;
                  s1_in.rsp.store_byte    = req_chan.received_byte;
                  s1_in.rsp.store_index   = position_ff;
                  position_in             = next_pos;
                  s1_in.rsp.control_set   = i2cms_pkg::CTL_STOP;
                  s1_in.rsp.control_clear = i2cms_pkg::CLR_SI_STA;
                  s1_in.rsp.finished      = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cms_pkg::MODE_PLAIN;
         bytes_left_ff <= '0;
         position_ff   <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         position_ff   <= position_in;
      end
   end

   // transmit buffer: load writes, every accepted beat reads the current slot
   always_ff @(posedge clock) begin
      if (fire && mem_we) mem[slot_of(req_chan.load_index)] <= req_chan.load_byte;
      if (fire) rd_data_ff <= mem[position_ff[AW-1:0]];
   end

   always_comb begin
      rsp_in = s1_ff.rsp;
      if (s1_ff.from_mem) rsp_in.send_byte = rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire)         s1_valid_ff <= 1'b1;
         else if (s1_move) s1_valid_ff <= 1'b0;
         if (s1_move)             rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire)    s1_ff  <= s1_in;
      if (s1_move) rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.send_valid    = rsp_ff.send_valid;
   assign rsp_chan.send_byte     = rsp_ff.send_byte;
   assign rsp_chan.control_set   = rsp_ff.control_set;
   assign rsp_chan.control_clear = rsp_ff.control_clear;
   assign rsp_chan.store_valid   = rsp_ff.store_valid;
   assign rsp_chan.store_byte    = rsp_ff.store_byte;
   assign rsp_chan.store_index   = rsp_ff.store_index;
   assign rsp_chan.finished      = rsp_ff.finished;
   assign rsp_chan.failed        = rsp_ff.failed;

endmodule
